// File: rtl/wds_pkg.sv
`default_nettype none

package wds_pkg;

    localparam int DATA_W    = 16;
    localparam int COUNT_W   = 5;
    localparam int MODE_W    = 2;
    localparam int REQ_W     = 2;
    localparam int WIDX_W    = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [REQ_W-1:0] REQ_DISPATCH = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DONE     = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FLUSH    = 2'd2;

    localparam logic [MODE_W-1:0] MODE_RR      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RAND    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LEAST   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SAMPLED = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED  = 2'd2;

    localparam logic [DATA_W-1:0]  LFSR_MASK   = 16'hB400;
    localparam logic [DATA_W-1:0]  SEED_RESET  = 16'h0001;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;
    localparam logic [COUNT_W-1:0] SAMPLE_MIN  = 5'd2;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [WIDX_W-1:0] worker_index;
        logic [DATA_W-1:0] task_tag;
    } wds_in_t;

    typedef struct packed {
        logic              dispatched;
        logic [WIDX_W-1:0] chosen_worker;
        logic [DATA_W-1:0] task_tag_out;
        logic              queue_full;
    } wds_out_t;

    // Source of the occupancy read address.
    typedef enum logic [2:0] {
        RS_WIDX = 3'd0,
        RS_ZERO = 3'd1,
        RS_SCAN = 3'd2,
        RS_BEST = 3'd3,
        RS_REM  = 3'd4,
        RS_SAMP = 3'd5
    } rd_src_t;

    // Operand selection for the modulo unit.
    typedef enum logic [1:0] {
        MS_RR   = 2'd0,
        MS_RAND = 2'd1,
        MS_SAMP = 2'd2
    } mod_src_t;

    typedef struct packed {
        logic     load_req;
        logic     flush;
        logic     rd_en;
        rd_src_t  rd_sel;
        logic     best_init;
        logic     cmp;
        logic     cnt_inc;
        logic     mod_start;
        mod_src_t mod_src;
        logic     ptr_load;
        logic     dec_wr;
        logic     inc_wr;
        logic     out_load;
    } wds_cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [MODE_W-1:0] mode;
        logic              widx_ok;
        logic              n_one;
        logic              scan_last;
        logic              smp_done;
        logic              best_zero;
        logic              mod_done;
        logic              out_free;
    } wds_stat_t;

    function automatic logic [DATA_W-1:0] lfsr_step(input logic [DATA_W-1:0] s);
        logic [DATA_W-1:0] shifted;
        shifted = s >> 1;
        if (s[0])
        begin
            shifted = shifted ^ LFSR_MASK;
        end
        return shifted;
    endfunction

    // Division by three through a reciprocal; exact for every 5-bit value.
    function automatic logic [COUNT_W-1:0] div3(input logic [COUNT_W-1:0] n);
        logic [9:0] prod;
        prod = 10'(n) * 10'd11;
        return prod[9:5];
    endfunction

endpackage

`default_nettype wire

// File: rtl/wds_ram.sv
`default_nettype none

module wds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/wds_mod.sv
`default_nettype none

module wds_mod (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [wds_pkg::DATA_W-1:0]    dividend,
    input  wire logic [wds_pkg::COUNT_W-1:0]   divisor,
    output      logic                          done,
    output      logic [wds_pkg::COUNT_W-1:0]   rem
);

    import wds_pkg::*;

    localparam int STEP_W = $clog2(DATA_W + 1);

    logic [DATA_W-1:0]  quo_reg, quo_next;
    logic [COUNT_W-1:0] rem_reg, rem_next;
    logic [COUNT_W-1:0] div_reg, div_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [COUNT_W:0]   trial;

    // One quotient bit per cycle, restoring form; only the remainder is kept.
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[DATA_W-1]};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
            step_next = STEP_W'(DATA_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = quo_reg << 1;
            if (trial >= {1'b0, div_reg})
            begin
                trial = trial - {1'b0, div_reg};
            end
            rem_next  = trial[COUNT_W-1:0];
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

// File: rtl/wds_dp.sv
`default_nettype none

module wds_dp #(
    parameter int NUM_WORKERS   = 16,
    parameter int OCCUPANCY_MAX = 255
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire wds_pkg::wds_in_t                in_data,
    output      wds_pkg::wds_out_t               out_data,
    output      logic                            out_valid,
    input  wire logic                            out_stall,
    input  wire logic                            cfg_valid,
    output      logic                            cfg_ready,
    input  wire logic [wds_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [wds_pkg::DATA_W-1:0]      cfg_data,
    input  wire wds_pkg::wds_cmd_t               cmd,
    output      wds_pkg::wds_stat_t              stat
);

    import wds_pkg::*;

    localparam int IDX_W = $clog2(NUM_WORKERS);
    localparam int OCC_W = $clog2(OCCUPANCY_MAX + 1);
    localparam int CNT_W = $clog2(NUM_WORKERS + 1);
    localparam logic [OCC_W-1:0] OCC_MAX = OCC_W'(OCCUPANCY_MAX);

    // Configuration and generator state.
    logic [MODE_W-1:0]  mode_reg, mode_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [DATA_W-1:0]  lfsr_reg, lfsr_next;
    logic [DATA_W-1:0]  lfsr_draw;
    logic               draw;

    // Working state for one transaction.
    wds_in_t            req_reg, req_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [IDX_W-1:0]   addr_reg, addr_next;
    logic [IDX_W-1:0]   best_reg, best_next;
    logic [OCC_W-1:0]   best_val_reg, best_val_next;
    logic [IDX_W-1:0]   ptr_reg, ptr_next;
    logic               full_reg, full_next;
    logic [NUM_WORKERS-1:0] vld_reg, vld_next;
    logic               vld_q_reg, vld_q_next;
    logic               out_valid_reg, out_valid_next;
    wds_out_t           out_data_reg, out_data_next;

    logic [COUNT_W-1:0] n_eff;
    logic [COUNT_W-1:0] n_div3;
    logic [COUNT_W-1:0] samples;
    logic [IDX_W-1:0]   rd_addr;
    logic [OCC_W-1:0]   ram_q;
    logic [OCC_W-1:0]   occ_q;
    logic               we;
    logic [OCC_W-1:0]   wdata;
    logic [DATA_W-1:0]  mod_dividend;
    logic [COUNT_W-1:0] mod_divisor;
    logic               mod_done;
    logic [COUNT_W-1:0] mod_rem;
    logic [31:0]        chosen_ext;

    assign cfg_ready = 1'b1;

    // Workers in use: zero counts as one, anything above the built count saturates.
    always_comb
    begin
        if (count_reg == '0)
        begin
            n_eff = COUNT_W'(1);
        end
        else if (32'(count_reg) > NUM_WORKERS)
        begin
            n_eff = COUNT_W'(NUM_WORKERS);
        end
        else
        begin
            n_eff = count_reg;
        end
        n_div3  = div3(n_eff);
        samples = (n_div3 < SAMPLE_MIN) ? SAMPLE_MIN : n_div3;
    end

    assign lfsr_draw = lfsr_step(lfsr_reg);
    assign draw      = cmd.mod_start && (cmd.mod_src != MS_RR);

    always_comb
    begin
        mode_next  = mode_reg;
        count_next = count_reg;
        lfsr_next  = lfsr_reg;
        if (draw)
        begin
            lfsr_next = lfsr_draw;
        end
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MODE:
                begin
                    mode_next = cfg_data[MODE_W-1:0];
                end
                CFG_COUNT:
                begin
                    count_next = cfg_data[COUNT_W-1:0];
                end
                CFG_SEED:
                begin
                    // An all-zero generator would never move, so zero loads one.
                    lfsr_next = (cfg_data == '0) ? SEED_RESET : cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Read address selection.
    always_comb
    begin
        case (cmd.rd_sel)
            RS_WIDX: rd_addr = IDX_W'(req_reg.worker_index);
            RS_ZERO: rd_addr = '0;
            RS_SCAN: rd_addr = cnt_reg[IDX_W-1:0];
            RS_BEST: rd_addr = best_reg;
            RS_REM:  rd_addr = IDX_W'(mod_rem);
            RS_SAMP: rd_addr = IDX_W'(32'(mod_rem) + 32'd1);
            default: rd_addr = '0;
        endcase
    end

    wds_ram #(
        .WIDTH (OCC_W),
        .DEPTH (NUM_WORKERS)
    ) u_occ_ram (
        .clk   (clk),
        .we    (we),
        .waddr (addr_reg),
        .wdata (wdata),
        .re    (cmd.rd_en),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    // An entry not written since reset or the last flush reads as empty.
    assign occ_q = vld_q_reg ? ram_q : '0;

    always_comb
    begin
        we    = 1'b0;
        wdata = occ_q + OCC_W'(1);
        if (cmd.dec_wr && (occ_q != '0))
        begin
            we    = 1'b1;
            wdata = occ_q - OCC_W'(1);
        end
        else if (cmd.inc_wr && (occ_q < OCC_MAX))
        begin
            we = 1'b1;
        end
    end

    always_comb
    begin
        case (cmd.mod_src)
            MS_RR:
            begin
                mod_dividend = DATA_W'(ptr_reg) + DATA_W'(1);
                mod_divisor  = n_eff;
            end
            MS_SAMP:
            begin
                mod_dividend = lfsr_draw;
                mod_divisor  = n_eff - COUNT_W'(1);
            end
            default:
            begin
                mod_dividend = lfsr_draw;
                mod_divisor  = n_eff;
            end
        endcase
    end

    wds_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.mod_start),
        .dividend (mod_dividend),
        .divisor  (mod_divisor),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    always_comb
    begin
        req_next       = req_reg;
        cnt_next       = cnt_reg;
        addr_next      = addr_reg;
        best_next      = best_reg;
        best_val_next  = best_val_reg;
        ptr_next       = ptr_reg;
        full_next      = full_reg;
        vld_next       = vld_reg;
        vld_q_next     = vld_q_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (cmd.load_req)
        begin
            req_next  = in_data;
            cnt_next  = '0;
            full_next = 1'b0;
        end
        if (cmd.cnt_inc)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        if (cmd.rd_en)
        begin
            addr_next  = rd_addr;
            vld_q_next = vld_reg[rd_addr];
        end
        if (cmd.best_init)
        begin
            best_next     = '0;
            best_val_next = '1;
        end
        else if (cmd.cmp && (occ_q < best_val_reg))
        begin
            best_next     = addr_reg;
            best_val_next = occ_q;
        end
        if (cmd.ptr_load)
        begin
            ptr_next = IDX_W'(mod_rem);
        end
        if (cmd.inc_wr && (occ_q >= OCC_MAX))
        begin
            full_next = 1'b1;
        end
        if (cmd.flush)
        begin
            vld_next = '0;
        end
        else if (we)
        begin
            vld_next[addr_reg] = 1'b1;
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = '0;
            if (req_reg.req_type == REQ_DISPATCH)
            begin
                out_data_next.dispatched    = 1'b1;
                out_data_next.chosen_worker = chosen_ext[WIDX_W-1:0];
                out_data_next.task_tag_out  = req_reg.task_tag;
                out_data_next.queue_full    = full_reg;
            end
        end
    end

    assign chosen_ext = 32'(addr_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_RR;
            count_reg     <= COUNT_RESET;
            lfsr_reg      <= SEED_RESET;
            ptr_reg       <= '0;
            vld_reg       <= '0;
            vld_q_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            count_reg     <= count_next;
            lfsr_reg      <= lfsr_next;
            ptr_reg       <= ptr_next;
            vld_reg       <= vld_next;
            vld_q_reg     <= vld_q_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        cnt_reg      <= cnt_next;
        addr_reg     <= addr_next;
        best_reg     <= best_next;
        best_val_reg <= best_val_next;
        full_reg     <= full_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        stat.req_type  = req_reg.req_type;
        stat.mode      = mode_reg;
        stat.widx_ok   = (32'(req_reg.worker_index) < NUM_WORKERS);
        stat.n_one     = (n_eff == COUNT_W'(1));
        stat.scan_last = (32'(cnt_reg) == 32'(n_eff));
        stat.smp_done  = (32'(cnt_reg) == 32'(samples));
        stat.best_zero = (best_val_reg == '0);
        stat.mod_done  = mod_done;
        stat.out_free  = !out_valid_reg || !out_stall;
    end

`ifndef SYNTHESIS
    a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |-> (32'(rd_addr) < NUM_WORKERS))
        else $error("occupancy read beyond the built workers");

    a_wr_marks_valid: assert property (@(posedge clk) disable iff (!rst_n)
        we |=> vld_reg[$past(addr_reg)])
        else $error("written occupancy entry not marked valid");

    a_chosen_in_use: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && (req_reg.req_type == REQ_DISPATCH))
            |-> (32'(addr_reg) < 32'(n_eff)))
        else $error("dispatch chose a worker outside those in use");
`endif

endmodule

`default_nettype wire

// File: rtl/wds_ctrl.sv
`default_nettype none

module wds_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output      logic                in_stall,
    input  wire wds_pkg::wds_stat_t  stat,
    output      wds_pkg::wds_cmd_t   cmd
);

    import wds_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE     = 10'b0000000001,
        ST_SEL      = 10'b0000000010,
        ST_LL_SCAN  = 10'b0000000100,
        ST_SMP_CMP  = 10'b0000001000,
        ST_SMP_CHK  = 10'b0000010000,
        ST_MOD_WAIT = 10'b0000100000,
        ST_RD_BEST  = 10'b0001000000,
        ST_DEC_WR   = 10'b0010000000,
        ST_UPD      = 10'b0100000000,
        ST_OUT      = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel  = RS_ZERO;
        cmd.mod_src = MS_RR;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_SEL;
                end
            end
            ST_SEL:
            begin
                case (stat.req_type)
                    REQ_DISPATCH:
                    begin
                        case (stat.mode)
                            MODE_RR:
                            begin
                                cmd.mod_start = 1'b1;
                                cmd.mod_src   = MS_RR;
                                state_next    = ST_MOD_WAIT;
                            end
                            MODE_RAND:
                            begin
                                cmd.mod_start = 1'b1;
                                cmd.mod_src   = MS_RAND;
                                state_next    = ST_MOD_WAIT;
                            end
                            MODE_LEAST:
                            begin
                                cmd.best_init = 1'b1;
                                cmd.rd_en     = 1'b1;
                                cmd.rd_sel    = RS_SCAN;
                                cmd.cnt_inc   = 1'b1;
                                state_next    = ST_LL_SCAN;
                            end
                            default:
                            begin
                                // Sampled mode starts from worker 0; a single worker
                                // is chosen outright without a draw.
                                cmd.rd_en  = 1'b1;
                                cmd.rd_sel = RS_ZERO;
                                if (stat.n_one)
                                begin
                                    state_next = ST_UPD;
                                end
                                else
                                begin
                                    cmd.best_init = 1'b1;
                                    state_next    = ST_SMP_CMP;
                                end
                            end
                        endcase
                    end
                    REQ_DONE:
                    begin
                        if (stat.widx_ok)
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RS_WIDX;
                            state_next = ST_DEC_WR;
                        end
                        else
                        begin
                            state_next = ST_OUT;
                        end
                    end
                    REQ_FLUSH:
                    begin
                        cmd.flush  = 1'b1;
                        state_next = ST_OUT;
                    end
                    default:
                    begin
                        state_next = ST_OUT;
                    end
                endcase
            end
            ST_LL_SCAN:
            begin
                // Compare the entry read last cycle while the next one is read.
                cmd.cmp = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = ST_RD_BEST;
                end
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_sel  = RS_SCAN;
                    cmd.cnt_inc = 1'b1;
                end
            end
            ST_SMP_CMP:
            begin
                cmd.cmp    = 1'b1;
                state_next = ST_SMP_CHK;
            end
            ST_SMP_CHK:
            begin
                if (stat.best_zero || stat.smp_done)
                begin
                    state_next = ST_RD_BEST;
                end
                else
                begin
                    cmd.mod_start = 1'b1;
                    cmd.mod_src   = MS_SAMP;
                    cmd.cnt_inc   = 1'b1;
                    state_next    = ST_MOD_WAIT;
                end
            end
            ST_MOD_WAIT:
            begin
                if (stat.mod_done)
                begin
                    cmd.rd_en = 1'b1;
                    case (stat.mode)
                        MODE_RR:
                        begin
                            cmd.ptr_load = 1'b1;
                            cmd.rd_sel   = RS_REM;
                            state_next   = ST_UPD;
                        end
                        MODE_SAMPLED:
                        begin
                            cmd.rd_sel = RS_SAMP;
                            state_next = ST_SMP_CMP;
                        end
                        default:
                        begin
                            cmd.rd_sel = RS_REM;
                            state_next = ST_UPD;
                        end
                    endcase
                end
            end
            ST_RD_BEST:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RS_BEST;
                state_next = ST_UPD;
            end
            ST_DEC_WR:
            begin
                cmd.dec_wr = 1'b1;
                state_next = ST_OUT;
            end
            ST_UPD:
            begin
                cmd.inc_wr = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_SEL))
        else $error("accepted transaction did not start decoding");

    a_result_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> stat.out_free)
        else $error("result loaded over one still waiting");

    a_mod_then_wait: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mod_start |=> (state_reg == ST_MOD_WAIT))
        else $error("modulo started without waiting for it");
`endif

endmodule

`default_nettype wire

// File: rtl/worker_dispatch_selector.sv
// Task dispatcher keeping an occupancy count per worker in a small RAM. One
// transaction is in flight at a time; the result sits in an output register,
// so the next transaction is taken while it waits. Every item gives exactly
// one result. A dispatch in round-robin or random mode is paced by the
// 16-step one-bit-per-cycle modulo unit. Least-loaded mode scans the n
// workers in use, as the scan reads one counter per cycle from the
// occupancy RAM. Sampled mode draws at most max(2, n/3) samples, each
// sample bounded by the modulo unit. Configuration writes are taken at once.
`default_nettype none

module worker_dispatch_selector #(
    parameter int NUM_WORKERS   = 16,
    parameter int OCCUPANCY_MAX = 255
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output      logic                            in_stall,
    input  wire wds_pkg::wds_in_t                in_data,
    output      logic                            out_valid,
    input  wire logic                            out_stall,
    output      wds_pkg::wds_out_t               out_data,
    input  wire logic                            cfg_valid,
    output      logic                            cfg_ready,
    input  wire logic [wds_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [wds_pkg::DATA_W-1:0]      cfg_data
);

    import wds_pkg::*;

    wds_cmd_t  cmd;
    wds_stat_t stat;

    wds_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    wds_dp #(
        .NUM_WORKERS   (NUM_WORKERS),
        .OCCUPANCY_MAX (OCCUPANCY_MAX)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

`default_nettype wire
